// ===== sv/ei4p_pkg.sv =====
package ei4p_pkg;

  // header byte positions within the frame
  localparam logic [6:0] POS_SRC_MAC   = 7'd6;
  localparam logic [6:0] POS_ETHERTYPE = 7'd12;
  localparam logic [6:0] POS_IPV4      = 7'd14;
  localparam logic [6:0] POS_PROTOCOL  = 7'd23;
  localparam logic [6:0] POS_SRC_IP    = 7'd26;
  localparam logic [6:0] POS_IP_END    = 7'd34;
  localparam logic [6:0] POS_MAX       = 7'd127;

  // protocol codes
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // uplink mac after reset: 00:00:00:00:00:01
  localparam logic [47:0] UPLINK_MAC_RESET = 48'h0000_0000_0001;

  // input stage as seen by the capture logic
  typedef struct packed {
    logic       valid;
    logic [7:0] frame_byte;
    logic       last_byte;
  } stage_t;

  // one frame summary
  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] source_mac;
    logic        is_ipv4;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [7:0]  ip_protocol;
    logic [15:0] source_port;
    logic [15:0] dst_port;
    logic        ports_valid;
    logic        from_uplink;
    logic        truncated;
  } summary_t;

endpackage

// ===== sv/ei4p_byte_if.sv =====
interface ei4p_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== sv/ei4p_sum_if.sv =====
interface ei4p_sum_if;
  logic        valid;
  logic        ready;
  logic [47:0] dst_mac;
  logic [47:0] source_mac;
  logic        is_ipv4;
  logic [31:0] source_ip;
  logic [31:0] dest_ip;
  logic [7:0]  ip_protocol;
  logic [15:0] source_port;
  logic [15:0] dst_port;
  logic        ports_valid;
  logic        from_uplink;
  logic        truncated;

  modport source (
    output valid, output dst_mac, output source_mac, output is_ipv4, output source_ip,
    output dest_ip, output ip_protocol, output source_port, output dst_port,
    output ports_valid, output from_uplink, output truncated, input ready
  );
  modport sink (
    input valid, input dst_mac, input source_mac, input is_ipv4, input source_ip,
    input dest_ip, input ip_protocol, input source_port, input dst_port,
    input ports_valid, input from_uplink, input truncated, output ready
  );
endinterface

// ===== sv/ei4p_cfg_if.sv =====
interface ei4p_cfg_if;
  logic        valid;
  logic        ready;
  logic [47:0] uplink_source_mac;

  modport source (output valid, output uplink_source_mac, input ready);
  modport sink (input valid, input uplink_source_mac, output ready);
endinterface

// ===== sv/ei4p_in_reg.sv =====
module ei4p_in_reg (
  input  logic               clk,
  input  logic               rst,
  ei4p_byte_if.sink          frames,
  input  logic               proceed,
  output ei4p_pkg::stage_t   stage
);

  logic       valid;
  logic [7:0] frame_byte;
  logic       last_byte;

  // stage is free when empty or when its item moves on this cycle
  assign frames.ready = !valid || proceed;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (frames.ready) begin
      valid <= frames.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (frames.valid && frames.ready) begin
      frame_byte <= frames.frame_byte;
      last_byte  <= frames.last_byte;
    end
  end

  assign stage.valid      = valid;
  assign stage.frame_byte = frame_byte;
  assign stage.last_byte  = last_byte;

endmodule

// ===== sv/ei4p_capture.sv =====
module ei4p_capture (
  input  logic                clk,
  input  logic                rst,
  input  ei4p_pkg::stage_t    stage,
  input  logic                take,
  input  logic [47:0]         uplink_mac,
  output ei4p_pkg::summary_t  summary
);

  logic [6:0]  byte_position;
  logic [3:0]  header_words;
  logic [47:0] dst_mac_capture;
  logic [47:0] source_mac_capture;
  logic [15:0] ethertype_capture;
  logic [7:0]  protocol_capture;
  logic [63:0] ip_address_capture;
  logic [31:0] port_capture;

  // captures with the current byte applied
  logic [3:0]  header_words_new;
  logic [47:0] dst_mac_new;
  logic [47:0] source_mac_new;
  logic [15:0] ethertype_new;
  logic [7:0]  protocol_new;
  logic [63:0] ip_address_new;
  logic [31:0] port_new;

  logic [6:0]  p;
  logic [7:0]  p8;
  logic [7:0]  b;
  logic [2:0]  dm_idx;
  logic [2:0]  sm_idx;
  logic [2:0]  ip_idx;
  logic [1:0]  pt_idx;
  logic [7:0]  base;
  logic [7:0]  port_off;
  logic        in_ports;
  logic [7:0]  n;
  logic        ipv4;
  logic [7:0]  proto;
  logic        pv;

  assign p  = byte_position;
  assign p8 = {1'b0, byte_position};
  assign b  = stage.frame_byte;

  // byte lane within each field
  assign dm_idx   = 3'(3'd5 - p[2:0]);
  assign sm_idx   = 3'(4'd11 - p[3:0]);
  assign ip_idx   = 3'(3'd1 - p[2:0]);
  assign header_words_new = (p == ei4p_pkg::POS_IPV4) ? b[3:0] : header_words;
  assign base     = 8'd14 + {2'b00, header_words_new, 2'b00};
  assign port_off = 8'(p8 - base);
  assign in_ports = (p8 >= base) && (p8 < 8'(base + 8'd4));
  assign pt_idx   = 2'(2'd3 - port_off[1:0]);

  // field capture
  always_comb begin
    dst_mac_new    = dst_mac_capture;
    source_mac_new = source_mac_capture;
    ethertype_new  = ethertype_capture;
    protocol_new   = protocol_capture;
    ip_address_new = ip_address_capture;
    port_new       = port_capture;
    if (p < ei4p_pkg::POS_SRC_MAC) begin
      dst_mac_new[{dm_idx, 3'b000} +: 8] = b;
    end else if (p < ei4p_pkg::POS_ETHERTYPE) begin
      source_mac_new[{sm_idx, 3'b000} +: 8] = b;
    end else if (p < ei4p_pkg::POS_IPV4) begin
      ethertype_new[{p[0] == 1'b0, 3'b000} +: 8] = b;
    end
    if (p == ei4p_pkg::POS_PROTOCOL) begin
      protocol_new = b;
    end
    if (p >= ei4p_pkg::POS_SRC_IP && p < ei4p_pkg::POS_IP_END) begin
      ip_address_new[{ip_idx, 3'b000} +: 8] = b;
    end
    if (in_ports) begin
      port_new[{pt_idx, 3'b000} +: 8] = b;
    end
  end

  // frame summary on the last byte
  assign n     = 8'(p8 + 8'd1);
  assign ipv4  = (n >= {1'b0, ei4p_pkg::POS_IPV4}) && (ethertype_new == ei4p_pkg::ETHERTYPE_IPV4);
  assign proto = ipv4 ? protocol_new : 8'd0;
  assign pv    = ipv4 && (proto == ei4p_pkg::PROTO_TCP || proto == ei4p_pkg::PROTO_UDP);

  always_comb begin
    summary.dst_mac     = dst_mac_new;
    summary.source_mac  = source_mac_new;
    summary.is_ipv4     = ipv4;
    summary.source_ip   = ipv4 ? ip_address_new[63:32] : 32'd0;
    summary.dest_ip     = ipv4 ? ip_address_new[31:0] : 32'd0;
    summary.ip_protocol = proto;
    summary.source_port = pv ? port_new[31:16] : 16'd0;
    summary.dst_port    = pv ? port_new[15:0] : 16'd0;
    summary.ports_valid = pv;
    summary.from_uplink = (source_mac_new == uplink_mac);
    summary.truncated   = (n < {1'b0, ei4p_pkg::POS_IPV4})
                       || (ipv4 && n < {1'b0, ei4p_pkg::POS_IP_END})
                       || (pv && n < 8'(base + 8'd4));
  end

  // frame state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst || (take && stage.last_byte)) begin
      byte_position      <= '0;
      header_words       <= '0;
      dst_mac_capture    <= '0;
      source_mac_capture <= '0;
      ethertype_capture  <= '0;
      protocol_capture   <= '0;
      ip_address_capture <= '0;
      port_capture       <= '0;
    end else if (take) begin
      byte_position      <= (p < ei4p_pkg::POS_MAX) ? 7'(p + 7'd1) : ei4p_pkg::POS_MAX;
      header_words       <= header_words_new;
      dst_mac_capture    <= dst_mac_new;
      source_mac_capture <= source_mac_new;
      ethertype_capture  <= ethertype_new;
      protocol_capture   <= protocol_new;
      ip_address_capture <= ip_address_new;
      port_capture       <= port_new;
    end
  end

endmodule

// ===== sv/ei4p_out_reg.sv =====
module ei4p_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  ei4p_pkg::summary_t  summary,
  output logic                out_free,
  ei4p_sum_if.source          summaries
);

  logic               valid;
  ei4p_pkg::summary_t result;

  assign out_free = !valid || summaries.ready;

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= load;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      result <= summary;
    end
  end

  assign summaries.valid       = valid;
  assign summaries.dst_mac     = result.dst_mac;
  assign summaries.source_mac  = result.source_mac;
  assign summaries.is_ipv4     = result.is_ipv4;
  assign summaries.source_ip   = result.source_ip;
  assign summaries.dest_ip     = result.dest_ip;
  assign summaries.ip_protocol = result.ip_protocol;
  assign summaries.source_port = result.source_port;
  assign summaries.dst_port    = result.dst_port;
  assign summaries.ports_valid = result.ports_valid;
  assign summaries.from_uplink = result.from_uplink;
  assign summaries.truncated   = result.truncated;

endmodule

// ===== sv/eth_ipv4_l4_header_parser.sv =====
// channel     dir  payload
// frames      in   frame_byte, last_byte
// summaries   out  dst_mac .. truncated, one per frame
// cfg         in   uplink_source_mac write
//
// one byte per cycle sustained unless a last byte waits on a full output; a
// byte sits in the input register before the capture logic takes it, and the
// summary is registered once the last byte is taken. reset clears the frame
// state and sets the uplink mac to 00:00:00:00:00:01. a waiting summary holds
// back only the next last byte; other bytes flow on into the capture state.
module eth_ipv4_l4_header_parser (
  input  logic        clk,
  input  logic        rst,
  ei4p_byte_if.sink   frames,
  ei4p_sum_if.source  summaries,
  ei4p_cfg_if.sink    cfg
);

  ei4p_pkg::stage_t   stage;
  ei4p_pkg::summary_t summary;
  logic               proceed;
  logic               load;
  logic               out_free;
  logic [47:0]        uplink_mac;

  // uplink mac register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      uplink_mac <= ei4p_pkg::UPLINK_MAC_RESET;
    end else if (cfg.valid && cfg.ready) begin
      uplink_mac <= cfg.uplink_source_mac;
    end
  end

  // a last byte needs room in the result register
  assign proceed = stage.valid && (!stage.last_byte || out_free);
  assign load    = proceed && stage.last_byte;

  ei4p_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .frames  (frames),
    .proceed (proceed),
    .stage   (stage)
  );

  ei4p_capture u_capture (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .take       (proceed),
    .uplink_mac (uplink_mac),
    .summary    (summary)
  );

  ei4p_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .summary   (summary),
    .out_free  (out_free),
    .summaries (summaries)
  );

`ifndef SYNTHESIS
  // a processed last byte always yields a summary next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> summaries.valid)
    else $error("summary missing after last byte");

  // ports only for ipv4 tcp or udp
  a_ports_proto: assert property (@(posedge clk) disable iff (rst)
    (summaries.valid && summaries.ports_valid) |->
      (summaries.is_ipv4 && (summaries.ip_protocol == ei4p_pkg::PROTO_TCP
                          || summaries.ip_protocol == ei4p_pkg::PROTO_UDP)))
    else $error("ports valid without tcp or udp");

  // non-ipv4 frames carry zero ip fields
  a_non_ipv4_zero: assert property (@(posedge clk) disable iff (rst)
    (summaries.valid && !summaries.is_ipv4) |->
      (summaries.source_ip == 32'd0 && summaries.dest_ip == 32'd0
       && summaries.ip_protocol == 8'd0 && !summaries.ports_valid))
    else $error("ip fields set on non-ipv4 frame");

  // a byte moves on only when it can be consumed
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (stage.valid && stage.last_byte && !out_free) |=> (stage.valid && stage.last_byte))
    else $error("held last byte lost");
`endif

endmodule

// ===== dv/tb_eth_ipv4_l4_header_parser.sv =====
module tb_eth_ipv4_l4_header_parser;
  timeunit 1ns;
  timeprecision 1ps;

  // ethertypes that must not be taken for ipv4
  localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef enum int {
    FK_TCP_UDP,
    FK_IPV4_OTHER,
    FK_NON_IPV4,
    FK_TRUNC,
    FK_NOISE,
    FK_LONG
  } frame_kind_t;

  logic clk;
  logic rst;

  ei4p_byte_if frames();
  ei4p_sum_if  summaries();
  ei4p_cfg_if  cfg();

  eth_ipv4_l4_header_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .frames    (frames),
    .summaries (summaries),
    .cfg       (cfg)
  );

  byte_item_t           pending_bytes[$];
  ei4p_pkg::summary_t   predicted_summaries[$];
  logic [7:0]           frame_buf[$];
  byte_item_t           next_byte;
  int                   send_idle_pct = 35;
  int                   recv_idle_pct = 74;
  int                   error_count = 0;

  // shadow of the parser state
  logic [47:0] uplink_mac;
  logic [6:0]  frame_pos;
  logic [3:0]  ihl_shadow;
  logic [47:0] dmac_shadow;
  logic [47:0] smac_shadow;
  logic [15:0] etype_shadow;
  logic [7:0]  proto_shadow;
  logic [63:0] ip_shadow;
  logic [31:0] port_shadow;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_error(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic clear_frame_state();
    frame_pos    = '0;
    ihl_shadow   = '0;
    dmac_shadow  = '0;
    smac_shadow  = '0;
    etype_shadow = '0;
    proto_shadow = '0;
    ip_shadow    = '0;
    port_shadow  = '0;
  endtask

  // capture one frame byte; on the last byte predict the summary
  task automatic parse_byte(input logic [7:0] b, input logic lst);
    int                 p;
    int                 n;
    int                 ihl;
    int                 base;
    logic               ipv4;
    logic               pv;
    logic [7:0]         proto;
    ei4p_pkg::summary_t s;
    p = frame_pos;
    if (p < 6) dmac_shadow = dmac_shadow | (48'(b) << (8 * (5 - p)));
    else if (p < 12) smac_shadow = smac_shadow | (48'(b) << (8 * (11 - p)));
    else if (p < 14) etype_shadow = etype_shadow | (16'(b) << (8 * (13 - p)));
    if (p == 14) ihl_shadow = b[3:0];
    if (p == 23) proto_shadow = b;
    if (p >= 26 && p < 34) ip_shadow = ip_shadow | (64'(b) << (8 * (33 - p)));
    ihl = (p == 14) ? int'(b[3:0]) : int'(ihl_shadow);
    base = 14 + 4 * ihl;
    if (p >= base && p < base + 4)
      port_shadow = port_shadow | (32'(b) << (8 * (3 - (p - base))));
    if (!lst) begin
      if (frame_pos != ei4p_pkg::POS_MAX) frame_pos = frame_pos + 7'd1;
      return;
    end
    n = p + 1;
    ipv4 = (n >= 14) && (etype_shadow == ei4p_pkg::ETHERTYPE_IPV4);
    proto = ipv4 ? proto_shadow : 8'd0;
    pv = ipv4 && (proto == ei4p_pkg::PROTO_TCP || proto == ei4p_pkg::PROTO_UDP);
    base = 14 + 4 * int'(ihl_shadow);
    s.dst_mac     = dmac_shadow;
    s.source_mac  = smac_shadow;
    s.is_ipv4     = ipv4;
    s.source_ip   = ipv4 ? ip_shadow[63:32] : 32'd0;
    s.dest_ip     = ipv4 ? ip_shadow[31:0] : 32'd0;
    s.ip_protocol = proto;
    s.source_port = pv ? port_shadow[31:16] : 16'd0;
    s.dst_port    = pv ? port_shadow[15:0] : 16'd0;
    s.ports_valid = pv;
    s.from_uplink = (smac_shadow == uplink_mac);
    s.truncated   = (n < 14) || (ipv4 && n < 34) || (pv && n < base + 4);
    predicted_summaries.push_back(s);
    clear_frame_state();
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report_error($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  task automatic check_summary();
    ei4p_pkg::summary_t want;
    if (predicted_summaries.size() == 0) begin
      report_error("summary item with no frame outstanding");
      return;
    end
    want = predicted_summaries.pop_front();
    compare_field("dst_mac", 64'(summaries.dst_mac), 64'(want.dst_mac));
    compare_field("source_mac", 64'(summaries.source_mac), 64'(want.source_mac));
    compare_field("is_ipv4", 64'(summaries.is_ipv4), 64'(want.is_ipv4));
    compare_field("source_ip", 64'(summaries.source_ip), 64'(want.source_ip));
    compare_field("dest_ip", 64'(summaries.dest_ip), 64'(want.dest_ip));
    compare_field("ip_protocol", 64'(summaries.ip_protocol), 64'(want.ip_protocol));
    compare_field("source_port", 64'(summaries.source_port), 64'(want.source_port));
    compare_field("dst_port", 64'(summaries.dst_port), 64'(want.dst_port));
    compare_field("ports_valid", 64'(summaries.ports_valid), 64'(want.ports_valid));
    compare_field("from_uplink", 64'(summaries.from_uplink), 64'(want.from_uplink));
    compare_field("truncated", 64'(summaries.truncated), 64'(want.truncated));
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      frames.valid <= 1'b0;
    end else if (!frames.valid || frames.ready) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_byte = pending_bytes.pop_front();
        frames.valid      <= 1'b1;
        frames.frame_byte <= next_byte.data;
        frames.last_byte  <= next_byte.last;
      end else begin
        frames.valid <= 1'b0;
      end
    end
  end

  // summary back-pressure
  always @(posedge clk) begin
    summaries.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // accepted bytes feed the predictor
  always @(posedge clk) begin
    if (rst) begin
      uplink_mac = ei4p_pkg::UPLINK_MAC_RESET;
      clear_frame_state();
    end else if (frames.valid && frames.ready) begin
      parse_byte(frames.frame_byte, frames.last_byte);
    end
  end

  // summary monitor
  always @(posedge clk) begin
    if (!rst && summaries.valid && summaries.ready) check_summary();
  end

  function automatic void put_byte(input int pos, input logic [7:0] v);
    if (pos < frame_buf.size()) frame_buf[pos] = v;
  endfunction

  function automatic void fill_frame(input int len, input logic [7:0] v);
    frame_buf.delete();
    for (int i = 0; i < len; i++) frame_buf.push_back(v);
  endfunction

  task automatic push_frame();
    byte_item_t it;
    foreach (frame_buf[i]) begin
      it.data = frame_buf[i];
      it.last = (i == frame_buf.size() - 1);
      pending_bytes.push_back(it);
    end
  endtask

  // random frame of the given kind into frame_buf
  task automatic build_frame(input frame_kind_t kind);
    int          ihl;
    int          need;
    int          len;
    logic [7:0]  proto;
    logic [47:0] smac;
    logic [15:0] etype;
    ihl = ($urandom_range(0, 4) != 0) ? 5 : $urandom_range(0, 15);
    need = (14 + 4 * ihl + 4 > 34) ? 14 + 4 * ihl + 4 : 34;
    case (kind)
      FK_NOISE: len = $urandom_range(1, 60);
      FK_LONG:  len = $urandom_range(128, 200);
      FK_TRUNC: len = $urandom_range(1, need - 1);
      default:  len = need + $urandom_range(0, 24);
    endcase
    frame_buf.delete();
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
    if (kind == FK_NOISE) return;
    // source mac often matches the uplink register
    if ($urandom_range(0, 2) == 0) smac = uplink_mac;
    else smac = {16'($urandom), 32'($urandom)};
    for (int i = 0; i < 6; i++) put_byte(6 + i, smac[8 * (5 - i) +: 8]);
    if (kind == FK_NON_IPV4) begin
      case ($urandom_range(0, 4))
        0:       etype = ETHERTYPE_IPV6;
        1:       etype = ETHERTYPE_ARP;
        2:       etype = ei4p_pkg::ETHERTYPE_IPV4 ^ 16'h0001;
        3:       etype = {ei4p_pkg::ETHERTYPE_IPV4[7:0], ei4p_pkg::ETHERTYPE_IPV4[15:8]};
        default: etype = 16'($urandom);
      endcase
    end else begin
      etype = ei4p_pkg::ETHERTYPE_IPV4;
    end
    put_byte(12, etype[15:8]);
    put_byte(13, etype[7:0]);
    if (frame_buf.size() > 14) frame_buf[14][3:0] = 4'(ihl);
    if (kind == FK_IPV4_OTHER) begin
      do proto = 8'($urandom_range(0, 255));
      while (proto == ei4p_pkg::PROTO_TCP || proto == ei4p_pkg::PROTO_UDP);
    end else begin
      proto = $urandom_range(0, 1) ? ei4p_pkg::PROTO_TCP : ei4p_pkg::PROTO_UDP;
    end
    put_byte(ei4p_pkg::POS_PROTOCOL, proto);
  endtask

  task automatic queue_random_frames(input int byte_target);
    int          queued = 0;
    int          r;
    frame_kind_t kind;
    while (queued < byte_target) begin
      r = $urandom_range(0, 99);
      if (r < 45) kind = FK_TCP_UDP;
      else if (r < 57) kind = FK_IPV4_OTHER;
      else if (r < 69) kind = FK_NON_IPV4;
      else if (r < 84) kind = FK_TRUNC;
      else if (r < 95) kind = FK_NOISE;
      else kind = FK_LONG;
      build_frame(kind);
      queued += frame_buf.size();
      push_frame();
    end
  endtask

  // edge cases: tiny frames, bare ethertype, ihl of zero and fifteen
  task automatic queue_directed_frames();
    fill_frame(1, 8'hFF);
    push_frame();
    fill_frame(1, 8'h00);
    push_frame();
    fill_frame(13, 8'hFF);
    push_frame();
    fill_frame(14, 8'h00);
    put_byte(11, 8'h01);
    put_byte(12, ei4p_pkg::ETHERTYPE_IPV4[15:8]);
    put_byte(13, ei4p_pkg::ETHERTYPE_IPV4[7:0]);
    push_frame();
    // ports overlap the ip header when ihl is zero
    fill_frame(34, 8'hFF);
    put_byte(12, ei4p_pkg::ETHERTYPE_IPV4[15:8]);
    put_byte(13, ei4p_pkg::ETHERTYPE_IPV4[7:0]);
    put_byte(14, 8'hF0);
    put_byte(ei4p_pkg::POS_PROTOCOL, ei4p_pkg::PROTO_UDP);
    push_frame();
    fill_frame(78, 8'hFF);
    put_byte(12, ei4p_pkg::ETHERTYPE_IPV4[15:8]);
    put_byte(13, ei4p_pkg::ETHERTYPE_IPV4[7:0]);
    put_byte(14, 8'h4F);
    put_byte(ei4p_pkg::POS_PROTOCOL, ei4p_pkg::PROTO_TCP);
    push_frame();
  endtask

  // drain bytes and summaries, then let the pipeline settle
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || frames.valid || predicted_summaries.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_uplink(input logic [47:0] mac);
    cfg.valid             <= 1'b1;
    cfg.uplink_source_mac <= mac;
    do @(posedge clk);
    while (!cfg.ready);
    uplink_mac = mac;
    cfg.valid <= 1'b0;
  endtask

  // main sequence
  initial begin
    rst                   = 1'b1;
    frames.valid          = 1'b0;
    frames.frame_byte     = '0;
    frames.last_byte      = 1'b0;
    summaries.ready       = 1'b0;
    cfg.valid             = 1'b0;
    cfg.uplink_source_mac = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_directed_frames();
    wait_idle();
    write_uplink(48'hFFFF_FFFF_FFFF);
    queue_random_frames(600);

    wait_idle();
    send_idle_pct = 74;
    recv_idle_pct = 35;
    write_uplink(48'h0);
    queue_random_frames(600);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_uplink({16'($urandom), 32'($urandom)});
    queue_random_frames(600);

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
